// ===== src/lpi_pkg.sv =====
// Shared types and constants for the LFSR permutation index generator.
// Used by every module of the block; depends on nothing else.
package lpi_pkg;

    localparam int DATA_W        = 16;
    localparam int HB_W          = 4;
    localparam int NUM_MASK_REGS = 4;
    localparam int ADDR_W        = 5;
    localparam int APB_DATA_W    = 32;

    localparam logic [DATA_W-1:0] DATA_LENGTH_RST = 16'd1;
    localparam logic [HB_W-1:0]   HIGH_BIT_RST    = 4'd15;

    typedef enum logic [2:0] {
        REG_DATA_LENGTH = 3'd0,
        REG_HIGH_BIT    = 3'd1,
        REG_MASK_ZERO   = 3'd2,
        REG_MASK_ONE    = 3'd3,
        REG_MASK_TWO    = 3'd4,
        REG_MASK_THREE  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        FUNC_INIT = 2'd0,
        FUNC_NEXT = 2'd1,
        FUNC_PREV = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef struct packed {
        logic [DATA_W-1:0]                    data_length;
        logic [HB_W-1:0]                      high_bit;
        logic [NUM_MASK_REGS-1:0][DATA_W-1:0] masks;
    } t_cfg;

    typedef struct packed {
        logic load_init;
        logic step;
        logic step_left;
        logic fin1;
        logic fin2;
    } t_ctrl;

endpackage

// ===== src/lpi_cfg_regs.sv =====
// APB register bank for data length, feedback bit position and tap masks.
// Depends on lpi_pkg.
module lpi_cfg_regs
    import lpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (w_idx)
                REG_DATA_LENGTH: n_cfg.data_length = pwdata[DATA_W-1:0];
                REG_HIGH_BIT:    n_cfg.high_bit    = pwdata[HB_W-1:0];
                REG_MASK_ZERO:   n_cfg.masks[0]    = pwdata[DATA_W-1:0];
                REG_MASK_ONE:    n_cfg.masks[1]    = pwdata[DATA_W-1:0];
                REG_MASK_TWO:    n_cfg.masks[2]    = pwdata[DATA_W-1:0];
                REG_MASK_THREE:  n_cfg.masks[3]    = pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DATA_LENGTH: prdata = APB_DATA_W'(r_cfg.data_length);
            REG_HIGH_BIT:    prdata = APB_DATA_W'(r_cfg.high_bit);
            REG_MASK_ZERO:   prdata = APB_DATA_W'(r_cfg.masks[0]);
            REG_MASK_ONE:    prdata = APB_DATA_W'(r_cfg.masks[1]);
            REG_MASK_TWO:    prdata = APB_DATA_W'(r_cfg.masks[2]);
            REG_MASK_THREE:  prdata = APB_DATA_W'(r_cfg.masks[3]);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_length <= DATA_LENGTH_RST;
            r_cfg.high_bit    <= HIGH_BIT_RST;
            r_cfg.masks       <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/lpi_datapath.sv =====
// LFSR state, shared step unit and the final offset correction of the index.
// Depends on lpi_pkg; driven by lpi_ctrl through a t_ctrl struct.
module lpi_datapath
    import lpi_pkg::*;
#(
    parameter int INDEX_WIDTH = 16,
    parameter int MASK_COUNT  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_ctrl             i_ctrl,
    input  logic [1:0]        i_seqno,
    output logic              o_above,
    output logic [DATA_W-1:0] o_index,
    output logic              o_index_valid
);

    localparam int IW = INDEX_WIDTH;
    localparam int WW = (IW > DATA_W) ? IW : DATA_W;

    logic [IW-1:0]     r_state;
    logic [IW-1:0]     r_mask;
    logic [IW-1:0]     r_offset;
    logic [IW-1:0]     r_acc;
    logic              r_lt;
    logic [DATA_W-1:0] r_index;
    logic              r_valid;

    logic [IW-1:0]     w_dl;
    logic [IW-1:0]     w_step;
    logic [IW-1:0]     w_hb_shift;
    logic              w_fb_left;
    logic [IW-1:0]     w_right;
    logic [IW-1:0]     w_left;
    logic [DATA_W-1:0] w_off16;
    logic [IW-1:0]     w_off;
    logic [IW-1:0]     w_sel_mask;
    logic [IW-1:0]     w_sum;

    assign w_dl = IW'(i_cfg.data_length);

    // Shared step unit: one Galois step in the selected direction.
    assign w_right    = (r_state >> 1) ^ (r_state[0] ? r_mask : '0);
    assign w_hb_shift = r_state >> i_cfg.high_bit;
    assign w_fb_left  = w_hb_shift[0];
    assign w_left     = (r_state << 1) ^ (w_fb_left ? {r_mask[IW-2:0], 1'b1} : '0);
    assign w_step     = i_ctrl.step_left ? w_left : w_right;
    assign o_above    = WW'(w_step) > WW'(i_cfg.data_length);

    assign w_off16    = i_cfg.data_length >> (3'd1 + 3'(i_seqno));
    assign w_off      = IW'(w_off16);
    assign w_sel_mask = (32'(i_seqno) < MASK_COUNT) ? IW'(i_cfg.masks[i_seqno]) : '0;
    assign w_sum      = r_acc + (r_lt ? w_dl : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_mask   <= '0;
            r_offset <= '0;
        end else if (i_ctrl.load_init) begin
            r_mask   <= w_sel_mask;
            r_offset <= w_off;
            r_state  <= IW'(i_seqno) + IW'(1) + w_off;
        end else if (i_ctrl.step) begin
            r_state  <= w_step;
        end
    end

    // The wrapped state minus one falls below the offset exactly when the
    // state is nonzero and no larger than the offset.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin1) begin
            r_acc <= r_state - IW'(1) - r_offset;
            r_lt  <= (r_state != '0) && (r_state <= r_offset);
        end
        if (i_ctrl.fin2) begin
            r_index <= DATA_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.fin2;
        end
    end

    assign o_index       = r_index;
    assign o_index_valid = r_valid;

endmodule

// ===== src/lpi_ctrl.sv =====
// Sequencer that runs the step unit until the state is accepted, then finishes.
// Depends on lpi_pkg; drives lpi_datapath through a t_ctrl struct.
module lpi_ctrl
    import lpi_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  logic       i_above,
    output t_ctrl      o_ctrl,
    output logic       o_busy
);

    localparam int IW = INDEX_WIDTH;
    localparam logic [IW:0] STEP_LIMIT = {1'b1, {IW{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_FIN1 = 4'b0100,
        S_FIN2 = 4'b1000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [IW:0] r_cnt;
    logic [IW:0] n_cnt;
    logic        r_left;
    logic        n_left;
    logic        w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_left  = r_left;
        o_ctrl  = '0;
        o_ctrl.step_left = r_left;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_func'(i_func))
                        FUNC_INIT: o_ctrl.load_init = 1'b1;
                        FUNC_NEXT: begin
                            n_state = S_STEP;
                            n_left  = 1'b0;
                            n_cnt   = '0;
                        end
                        FUNC_PREV: begin
                            n_state = S_STEP;
                            n_left  = 1'b1;
                            n_cnt   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP: begin
                o_ctrl.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (!i_above || (n_cnt == STEP_LIMIT)) begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: begin
                o_ctrl.fin1 = 1'b1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                o_ctrl.fin2 = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_left  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
        end
    end

endmodule

// ===== src/lfsr_permutation_index.sv =====
// An init beat is taken without raising busy and gives no result. A next or prev beat keeps
// the block busy while S_STEP runs the N LFSR steps the rejection loop needs (one step per
// cycle through the single shared step unit, at least one, at most 2^INDEX_WIDTH), then
// through S_FIN1 and S_FIN2; the index strobe shows in the first cycle with busy low and
// lasts one cycle. The receiver cannot stall, so each index must be taken as it shows.
// Top level of the LFSR permutation index generator; depends on lpi_pkg,
// lpi_cfg_regs, lpi_ctrl and lpi_datapath.
module lfsr_permutation_index
    import lpi_pkg::*;
#(
    parameter int INDEX_WIDTH = 16,
    parameter int MASK_COUNT  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [1:0]            i_seqno,
    output logic                  o_index_valid,
    output logic [DATA_W-1:0]     o_index
);

    t_cfg  w_cfg;
    t_ctrl w_ctrl;
    logic  w_above;

    lpi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpi_ctrl #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_above (w_above),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    lpi_datapath #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .MASK_COUNT  (MASK_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_ctrl        (w_ctrl),
        .i_seqno       (i_seqno),
        .o_above       (w_above),
        .o_index       (o_index),
        .o_index_valid (o_index_valid)
    );

endmodule

// ===== src/lpi_checker.sv =====
// Port-level checks on the LFSR permutation index generator, bound to its top level.
// Depends on lpi_pkg and lfsr_permutation_index.
module lpi_checker
    import lpi_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [1:0]            i_func,
    input logic                  o_index_valid,
    input logic [DATA_W-1:0]     o_index
);

    logic w_acc_step;
    logic w_acc_other;

    assign w_acc_step  = start && !busy && (i_func == FUNC_NEXT || i_func == FUNC_PREV);
    assign w_acc_other = start && !busy && (i_func == FUNC_INIT || i_func == FUNC_NONE);

    a_step_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_step |=> busy)
        else $error("step beat accepted but block not busy");

    a_other_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_other |=> (!busy && !o_index_valid))
        else $error("init or unused beat started work");

    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_index_valid)
        else $error("busy dropped without a result beat");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_index_valid |-> (!busy && !$past(o_index_valid)))
        else $error("result beat overlaps busy or repeats");

    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_index_valid |-> !$isunknown(o_index))
        else $error("result beat carries an unknown index");

endmodule

bind lfsr_permutation_index lpi_checker u_lpi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .o_index_valid (o_index_valid),
    .o_index       (o_index)
);
